[design/cmt_pkg.sv]
// Package for the contour median tangent block.
// Holds the transaction types, the datapath widths and the arctangent table.
// Used by every module of the block; it depends on nothing.
package cmt_pkg;

  localparam int COORD_BITS   = 12;
  localparam int HALF_WINDOW  = 5;
  localparam int ORIENT_W     = 16;
  localparam int ANGLE_W      = 15;            // one folded angle, 0..16384
  localparam int DIFF_W       = COORD_BITS + 1; // signed coordinate difference
  localparam int CORDIC_STEPS = 16;
  localparam int SHIFT_W      = 4;
  localparam int PRE_SHIFT    = 14;
  localparam int XY_W         = 30;
  localparam int Z_W          = 20;
  localparam int Z_MAX        = 131072;
  localparam int ANGLE_PI     = 16384;
  localparam int ANGLE_HALF   = 8192;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  end_of_contour;
  } point_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [ORIENT_W-1:0]   orientation;
    logic                  orientation_valid;
    logic                  contour_end;
  } result_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } coord_t;

  // Control of the shared CORDIC unit.
  typedef struct packed {
    logic               load;
    logic               iterate;
    logic [SHIFT_W-1:0] shift;
  } cordic_ctl_t;

  // Control of the angle sorter.
  typedef struct packed {
    logic wr_en;
    logic step_en;
    logic step_odd;
  } sort_ctl_t;

  // Arctangent of 2^-i in units of pi/262144.
  function automatic logic signed [Z_W-1:0] atan_step(logic [SHIFT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = Z_W'(65536);
      4'd1:    v = Z_W'(38688);
      4'd2:    v = Z_W'(20442);
      4'd3:    v = Z_W'(10377);
      4'd4:    v = Z_W'(5208);
      4'd5:    v = Z_W'(2607);
      4'd6:    v = Z_W'(1304);
      4'd7:    v = Z_W'(652);
      4'd8:    v = Z_W'(326);
      4'd9:    v = Z_W'(163);
      4'd10:   v = Z_W'(81);
      4'd11:   v = Z_W'(41);
      4'd12:   v = Z_W'(20);
      4'd13:   v = Z_W'(10);
      4'd14:   v = Z_W'(5);
      default: v = Z_W'(3);
    endcase
    return v;
  endfunction

endpackage

[design/cmt_cordic.sv]
// Shared CORDIC vectoring unit: folds one difference vector into [0,pi]
// and runs one rotation step per cycle while iterate is set. Depends on cmt_pkg.
module cmt_cordic (
  input  logic                                clk,
  input  cmt_pkg::cordic_ctl_t                ctl,
  input  logic signed [cmt_pkg::DIFF_W-1:0]   dx,
  input  logic signed [cmt_pkg::DIFF_W-1:0]   dy,
  output logic        [cmt_pkg::ANGLE_W-1:0]  angle
);

  logic signed [cmt_pkg::XY_W-1:0]   x;
  logic signed [cmt_pkg::XY_W-1:0]   y;
  logic signed [cmt_pkg::Z_W-1:0]    z;
  logic                              neg_x;
  logic                              special;
  logic        [cmt_pkg::ANGLE_W-1:0] special_val;

  logic signed [cmt_pkg::DIFF_W-1:0] fdx;
  logic signed [cmt_pkg::DIFF_W-1:0] fdy;
  logic signed [cmt_pkg::DIFF_W-1:0] adx;
  logic signed [cmt_pkg::XY_W-1:0]   xs;
  logic signed [cmt_pkg::XY_W-1:0]   ys;
  logic        [17:0]                zc;
  logic        [13:0]                t;

  // Fold the vector into the upper half plane.
  always_comb begin
    fdx = (dy < 0) ? -dx : dx;
    fdy = (dy < 0) ? -dy : dy;
    adx = (fdx < 0) ? -fdx : fdx;
    xs  = x >>> ctl.shift;
    ys  = y >>> ctl.shift;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x       <= cmt_pkg::XY_W'(adx) <<< cmt_pkg::PRE_SHIFT;
      y       <= cmt_pkg::XY_W'(fdy) <<< cmt_pkg::PRE_SHIFT;
      z       <= '0;
      neg_x   <= (fdx < 0);
      special <= (fdy == 0) || (fdx == 0);
      if (fdy == 0) begin
        special_val <= (fdx < 0) ? cmt_pkg::ANGLE_W'(cmt_pkg::ANGLE_PI) : '0;
      end else begin
        special_val <= cmt_pkg::ANGLE_W'(cmt_pkg::ANGLE_HALF);
      end
    end else if (ctl.iterate) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + cmt_pkg::atan_step(ctl.shift);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - cmt_pkg::atan_step(ctl.shift);
      end
    end
  end

  // Clamp, round to pi/16384 and mirror for a leftward vector; an axis-aligned vector takes its special value.
  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > cmt_pkg::Z_W'(cmt_pkg::Z_MAX)) begin
      zc = 18'(cmt_pkg::Z_MAX);
    end else begin
      zc = z[17:0];
    end
    t = 14'((19'(zc) + 19'd8) >> 4);
    if (special) begin
      angle = special_val;
    end else if (neg_x) begin
      angle = cmt_pkg::ANGLE_W'(cmt_pkg::ANGLE_PI) - cmt_pkg::ANGLE_W'(t);
    end else begin
      angle = cmt_pkg::ANGLE_W'(t);
    end
  end

endmodule

[design/cmt_sort.sv]
// Angle store with odd-even transposition sorting, one pass per step.
// Gives the sum of the two middle angles. Depends on cmt_pkg.
module cmt_sort #(
  parameter int HALF_WINDOW = cmt_pkg::HALF_WINDOW
) (
  input  logic                                     clk,
  input  cmt_pkg::sort_ctl_t                       ctl,
  input  logic [$clog2(2*HALF_WINDOW)-1:0]         wr_idx,
  input  logic [cmt_pkg::ANGLE_W-1:0]              wr_val,
  output logic [cmt_pkg::ORIENT_W-1:0]             mid_sum
);

  localparam int NUM = 2 * HALF_WINDOW;

  logic [cmt_pkg::ANGLE_W-1:0] ang [NUM];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ang[wr_idx] <= wr_val;
    end else if (ctl.step_en) begin
      for (int i = 0; i < NUM - 1; i++) begin
        if ((i[0] == ctl.step_odd) && (ang[i] > ang[i+1])) begin
          ang[i]   <= ang[i+1];
          ang[i+1] <= ang[i];
        end
      end
    end
  end

  assign mid_sum = cmt_pkg::ORIENT_W'(ang[HALF_WINDOW-1])
                 + cmt_pkg::ORIENT_W'(ang[HALF_WINDOW]);

endmodule

[design/contour_median_tangent.sv]
// Contour median tangent: a point that only releases edge results goes straight to the
// output; when the window is full, the shared CORDIC first computes each angle in turn,
// the angles are sorted, and then the centre result and any flushed edge points go out.
// One point at a time: no new point is taken until the last one's results are all released.
// Synchronous reset clears the sequencer, the point count and the output valid; the point
// window itself is not cleared and is only read where it was written.
module contour_median_tangent #(
  parameter int HALF_WINDOW = cmt_pkg::HALF_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmt_pkg::point_item_t  point,
  input  logic                  point_valid,
  output logic                  point_stall,
  output cmt_pkg::result_item_t result,
  output logic                  result_valid,
  input  logic                  result_stall
);

  localparam int WIN      = 2 * HALF_WINDOW + 1;
  localparam int NUM      = 2 * HALF_WINDOW;
  localparam int IDX_W    = $clog2(WIN);
  localparam int CNT_W    = $clog2(WIN + 1);
  localparam int K_W      = $clog2(NUM);
  localparam int PASS_W   = $clog2(NUM + 1);
  localparam int STEP_W   = 5;
  localparam int STEP_WR  = cmt_pkg::CORDIC_STEPS + 1;

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    ANGLE = 4'b0010,
    SORT  = 4'b0100,
    EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  cmt_pkg::coord_t        window [WIN];
  logic [CNT_W-1:0]       seen;
  logic [K_W-1:0]         k;
  logic [STEP_W-1:0]      step;
  logic [PASS_W-1:0]      pass;
  logic [IDX_W-1:0]       emit_pos;
  logic [IDX_W-1:0]       emit_stop;
  logic                   last;
  logic                   full;

  logic                   accept;
  logic [CNT_W-1:0]       n_new;
  logic [IDX_W-1:0]       j;
  logic [IDX_W-1:0]       rd_idx;
  cmt_pkg::coord_t        other;
  cmt_pkg::coord_t        centre;
  logic signed [cmt_pkg::DIFF_W-1:0] diff_x;
  logic signed [cmt_pkg::DIFF_W-1:0] diff_y;
  logic signed [cmt_pkg::DIFF_W-1:0] dx;
  logic signed [cmt_pkg::DIFF_W-1:0] dy;
  cmt_pkg::cordic_ctl_t   cordic_ctl;
  cmt_pkg::sort_ctl_t     sort_ctl;
  logic [cmt_pkg::ANGLE_W-1:0]  angle;
  logic [cmt_pkg::ORIENT_W-1:0] mid_sum;
  logic                   out_free;
  logic                   emit_centre;

  // The block takes a new point only between transactions.
  assign point_stall = (state != IDLE);
  assign accept      = point_valid && !point_stall;
  assign n_new       = (seen == CNT_W'(WIN)) ? CNT_W'(WIN) : seen + CNT_W'(1);
  assign out_free    = !result_valid || !result_stall;

  // Angle k pairs the centre with window entry k, skipping the centre.
  assign j      = (k < K_W'(HALF_WINDOW)) ? IDX_W'(k) : IDX_W'(k) + IDX_W'(1);
  assign rd_idx = (state == ANGLE) ? j : emit_pos;
  assign other  = window[rd_idx];
  assign centre = window[HALF_WINDOW];

  // Difference toward the later point with the row axis pointing up.
  always_comb begin
    diff_x = cmt_pkg::DIFF_W'(other.x) - cmt_pkg::DIFF_W'(centre.x);
    diff_y = cmt_pkg::DIFF_W'(centre.y) - cmt_pkg::DIFF_W'(other.y);
    if (k < K_W'(HALF_WINDOW)) begin
      dx = -diff_x;
      dy = -diff_y;
    end else begin
      dx = diff_x;
      dy = diff_y;
    end
  end

  always_comb begin
    cordic_ctl.load    = (state == ANGLE) && (step == '0);
    cordic_ctl.iterate = (state == ANGLE) && (step != '0) && (step != STEP_W'(STEP_WR));
    cordic_ctl.shift   = cmt_pkg::SHIFT_W'(step - STEP_W'(1));
    sort_ctl.wr_en     = (state == ANGLE) && (step == STEP_W'(STEP_WR));
    sort_ctl.step_en   = (state == SORT);
    sort_ctl.step_odd  = pass[0];
  end

  cmt_cordic u_cordic (
    .clk   (clk),
    .ctl   (cordic_ctl),
    .dx    (dx),
    .dy    (dy),
    .angle (angle)
  );

  cmt_sort #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_sort (
    .clk     (clk),
    .ctl     (sort_ctl),
    .wr_idx  (k),
    .wr_val  (angle),
    .mid_sum (mid_sum)
  );

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          if (n_new == CNT_W'(WIN)) begin
            state_next = ANGLE;
          end else if ((n_new <= CNT_W'(HALF_WINDOW)) || point.end_of_contour) begin
            state_next = EMIT;
          end
        end
      end
      ANGLE: begin
        if ((step == STEP_W'(STEP_WR)) && (k == K_W'(NUM - 1))) begin
          state_next = SORT;
        end
      end
      SORT: begin
        if (pass == PASS_W'(NUM - 1)) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (out_free && (emit_pos == emit_stop)) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      seen  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        seen <= point.end_of_contour ? '0 : n_new;
      end
    end
  end

  // Window fill and slide; the window is a shift line once full.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen == CNT_W'(WIN)) begin
        for (int i = 0; i < WIN - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WIN-1] <= '{x: point.point_x, y: point.point_y};
      end else begin
        window[seen[IDX_W-1:0]] <= '{x: point.point_x, y: point.point_y};
      end
    end
  end

  // Sequencer counters and the span of window entries to release.
  always_ff @(posedge clk) begin
    if (accept) begin
      last <= point.end_of_contour;
      full <= (n_new == CNT_W'(WIN));
      k    <= '0;
      step <= '0;
      pass <= '0;
      if (n_new == CNT_W'(WIN)) begin
        emit_pos  <= IDX_W'(HALF_WINDOW);
        emit_stop <= point.end_of_contour ? IDX_W'(NUM) : IDX_W'(HALF_WINDOW);
      end else if (n_new <= CNT_W'(HALF_WINDOW)) begin
        emit_pos  <= IDX_W'(n_new - CNT_W'(1));
        emit_stop <= IDX_W'(n_new - CNT_W'(1));
      end else begin
        emit_pos  <= IDX_W'(HALF_WINDOW);
        emit_stop <= IDX_W'(n_new - CNT_W'(1));
      end
    end else begin
      case (state)
        ANGLE: begin
          if (step == STEP_W'(STEP_WR)) begin
            step <= '0;
            k    <= k + K_W'(1);
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        SORT: pass <= pass + PASS_W'(1);
        EMIT: begin
          if (out_free && (emit_pos != emit_stop)) begin
            emit_pos <= emit_pos + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: the consumer may stall while the block starts the next point.
  assign emit_centre = full && (emit_pos == IDX_W'(HALF_WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == EMIT) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == EMIT) && out_free) begin
      result.out_x             <= other.x;
      result.out_y             <= other.y;
      result.orientation       <= emit_centre ? mid_sum : '0;
      result.orientation_valid <= emit_centre;
      result.contour_end       <= last && (emit_pos == emit_stop);
    end
  end

  // A computed orientation never exceeds pi in units of pi/32768.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.orientation_valid |-> result.orientation <= 16'd32768)
    else $error("orientation out of range");

  // Edge and short-contour results carry a zero orientation.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.orientation_valid |-> result.orientation == '0)
    else $error("invalid result with nonzero orientation");

  // The point count never passes the window length.
  assert property (@(posedge clk) disable iff (rst) seen <= CNT_W'(WIN))
    else $error("point count overflow");

  // An end-of-contour transaction leaves the count cleared.
  assert property (@(posedge clk) disable iff (rst)
    accept && point.end_of_contour |=> seen == '0)
    else $error("count not cleared at contour end");

endmodule

[sim/tb_contour_median_tangent.sv]
// Testbench for the contour median tangent block: directed and random contours in, checked results out.
// A built-in predictor computes the expected orientations; depends on cmt_pkg and the RTL.
module tb_contour_median_tangent;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LEN = 2 * cmt_pkg::HALF_WINDOW + 1;
  localparam int NUM_ANG = 2 * cmt_pkg::HALF_WINDOW;

  logic clk = 1'b0;
  logic rst = 1'b1;
  cmt_pkg::point_item_t point = '0;
  logic point_valid = 1'b0;
  logic point_stall;
  cmt_pkg::result_item_t result;
  logic result_valid;
  logic result_stall = 1'b0;

  contour_median_tangent dut (
    .clk(clk), .rst(rst),
    .point(point), .point_valid(point_valid), .point_stall(point_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall)
  );

  always #5 clk = ~clk;

  // Points waiting to be sent, and results the predictor says must come back.
  cmt_pkg::point_item_t pending_points[$];
  cmt_pkg::result_item_t expected_results[$];
  int mismatches = 0;
  bit stim_done = 1'b0;

  // Predictor state: its own copy of the point window and the fill count.
  cmt_pkg::coord_t win[WIN_LEN];
  int fill = 0;

  // Folded direction angle in units of pi/16384, using CORDIC vectoring.
  function automatic int fold_angle(longint dx, longint dy);
    longint x, y, z, nx, ny;
    int t;
    bit neg_x;
    if (dy < 0) begin
      dx = -dx;
      dy = -dy;
    end
    if (dy == 0) return (dx < 0) ? cmt_pkg::ANGLE_PI : 0;
    if (dx == 0) return cmt_pkg::ANGLE_HALF;
    neg_x = dx < 0;
    x = (neg_x ? -dx : dx) <<< cmt_pkg::PRE_SHIFT;
    y = dy <<< cmt_pkg::PRE_SHIFT;
    z = 0;
    for (int i = 0; i < cmt_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(cmt_pkg::atan_step(i[cmt_pkg::SHIFT_W-1:0]));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(cmt_pkg::atan_step(i[cmt_pkg::SHIFT_W-1:0]));
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > cmt_pkg::Z_MAX) z = cmt_pkg::Z_MAX;
    t = int'((z + 8) >>> 4);
    return neg_x ? cmt_pkg::ANGLE_PI - t : t;
  endfunction

  // Median of the angles from the window centre to its neighbors on each side, as the sum of the two middle angles.
  function automatic logic [cmt_pkg::ORIENT_W-1:0] centre_tangent();
    int ang[NUM_ANG];
    int k, v, m;
    cmt_pkg::coord_t c;
    c = win[cmt_pkg::HALF_WINDOW];
    k = 0;
    for (int j = 0; j < cmt_pkg::HALF_WINDOW; j++)
      ang[k++] = fold_angle(longint'(c.x) - longint'(win[j].x),
                            longint'(win[j].y) - longint'(c.y));
    for (int j = cmt_pkg::HALF_WINDOW + 1; j < WIN_LEN; j++)
      ang[k++] = fold_angle(longint'(win[j].x) - longint'(c.x),
                            longint'(c.y) - longint'(win[j].y));
    for (int j = 1; j < NUM_ANG; j++) begin
      v = ang[j];
      m = j;
      while (m > 0 && ang[m-1] > v) begin
        ang[m] = ang[m-1];
        m--;
      end
      ang[m] = v;
    end
    return cmt_pkg::ORIENT_W'(ang[cmt_pkg::HALF_WINDOW-1] + ang[cmt_pkg::HALF_WINDOW]);
  endfunction

  function automatic cmt_pkg::result_item_t make_result(cmt_pkg::coord_t p,
                                                        logic [cmt_pkg::ORIENT_W-1:0] o,
                                                        logic v);
    cmt_pkg::result_item_t r;
    r.out_x = p.x;
    r.out_y = p.y;
    r.orientation = o;
    r.orientation_valid = v;
    r.contour_end = 1'b0;
    return r;
  endfunction

  // Advance the predictor by one accepted point and queue its results.
  task automatic predict_point(cmt_pkg::point_item_t it);
    cmt_pkg::coord_t p;
    cmt_pkg::result_item_t batch[$];
    int first;
    p.x = it.point_x;
    p.y = it.point_y;
    if (fill >= WIN_LEN) begin
      for (int j = 0; j < WIN_LEN - 1; j++) win[j] = win[j+1];
      win[WIN_LEN-1] = p;
    end else begin
      win[fill] = p;
      fill++;
    end
    if (fill <= cmt_pkg::HALF_WINDOW)
      batch.insert(batch.size(), make_result(win[fill-1], '0, 1'b0));
    else if (fill == WIN_LEN)
      batch.insert(batch.size(),
                   make_result(win[cmt_pkg::HALF_WINDOW], centre_tangent(), 1'b1));
    if (it.end_of_contour) begin
      // Flush the points still waiting behind the centre as invalid edge points.
      first = (fill == WIN_LEN) ? cmt_pkg::HALF_WINDOW + 1 : cmt_pkg::HALF_WINDOW;
      for (int q = first; q < fill; q++)
        batch.insert(batch.size(), make_result(win[q], '0, 1'b0));
      batch[batch.size()-1].contour_end = 1'b1;
      fill = 0;
    end
    foreach (batch[i]) expected_results.insert(expected_results.size(), batch[i]);
  endtask

  // Gap length: mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic cmt_pkg::point_item_t mk_point(int x, int y, bit last);
    cmt_pkg::point_item_t it;
    it.point_x = cmt_pkg::COORD_BITS'(x);
    it.point_y = cmt_pkg::COORD_BITS'(y);
    it.end_of_contour = last;
    return it;
  endfunction

  // Random contour of n points: a walk of small steps with random far jumps.
  task automatic add_contour(int n);
    int x, y;
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end else begin
        x = (x + $urandom_range(0, 4) - 2) & 12'hFFF;
        y = (y + $urandom_range(0, 4) - 2) & 12'hFFF;
      end
      pending_points.insert(pending_points.size(), mk_point(x, y, i == n - 1));
    end
  endtask

  // Driver: the payload holds while stalled; a new transaction is loaded
  // only after the current one was accepted or none was offered.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (!point_valid || !point_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          point_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point <= pending_points.pop_front();
          point_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // The predictor runs on each accepted point.
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall) predict_point(point);
  end

  // Receiver stall: random runs of stall and ready.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 3) == 0);
      stall_left <= pick_gap();
    end
  end

  // Monitor: every accepted result is compared with the oldest expectation.
  cmt_pkg::result_item_t want;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = expected_results.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, got %p", want, result);
        end
      end
    end
  end

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: a short contour, a single point, a full window of coordinate
    // extremes, then one long contour along a row, a column and a diagonal.
    for (int i = 0; i < 3; i++)
      pending_points.insert(pending_points.size(), mk_point(i, 4095, i == 2));
    pending_points.insert(pending_points.size(), mk_point(4095, 0, 1'b1));
    for (int i = 0; i < 11; i++)
      pending_points.insert(pending_points.size(),
                            mk_point((i % 2) ? 4095 : 0, (i % 3) ? 0 : 4095, i == 10));
    for (int i = 0; i < 12; i++)
      pending_points.insert(pending_points.size(), mk_point(100 + i, 200, 1'b0));
    for (int i = 0; i < 12; i++)
      pending_points.insert(pending_points.size(), mk_point(300, 200 + i, 1'b0));
    for (int i = 0; i < 12; i++)
      pending_points.insert(pending_points.size(), mk_point(500 - i, 500 + i, i == 11));
    // Random contours, mostly long enough to fill the window.
    n = 0;
    while (n < 50) begin
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 30);
      add_contour(len);
      n += len;
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_points.size() > 0 || point_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // At most about 130 points are sent, and even under the longest gaps and stalls the run
  // ends far inside this limit.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[files.f]
design/cmt_pkg.sv
design/cmt_cordic.sv
design/cmt_sort.sv
design/contour_median_tangent.sv
sim/tb_contour_median_tangent.sv
